@@ rtl/sipf_pkg.sv @@
// Shared types, character codes and keyword table for the SIP stream message framer.
// Used by sipf_step and sip_stream_message_framer; depends on nothing.
package sipf_pkg;

  // Character codes the parser looks for.
  localparam logic [7:0] CHAR_CR      = 8'h0D;
  localparam logic [7:0] CHAR_LF      = 8'h0A;
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_C = 8'h63;
  localparam logic [7:0] CHAR_LOWER_L = 8'h6C;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // Length of the long header name, including its colon.
  localparam logic [3:0] KW_LEN = 4'd15;

  // Reset value of the message size limit.
  localparam logic [15:0] MAX_MSG_RESET = 16'hFFFF;

  // Progress through a header terminator.
  typedef enum logic [2:0] {
    TERM_NONE   = 3'd0,
    TERM_CR     = 3'd1,
    TERM_CRLF   = 3'd2,
    TERM_CRLFCR = 3'd3,
    TERM_LF     = 3'd4
  } term_t;

  // Which header name is being matched on the current line.
  typedef enum logic [1:0] {
    KW_NONE    = 2'd0,
    KW_LONG    = 2'd1,
    KW_COMPACT = 2'd2
  } kw_kind_t;

  // Phase of the length value parse.
  typedef enum logic [1:0] {
    VAL_IDLE   = 2'd0,
    VAL_BLANKS = 2'd1,
    VAL_DIGITS = 2'd2,
    VAL_DONE   = 2'd3
  } val_phase_t;

  // Parser state that does not scale with the counter width.
  typedef struct packed {
    logic       in_body_phase;
    term_t      term;
    logic       at_line_start;
    logic [3:0] kw_idx;
    kw_kind_t   kw_kind;
    logic       length_found;
    val_phase_t val_phase;
  } hdr_state_t;

  localparam hdr_state_t HDR_CLEAR = '{
    in_body_phase: 1'b0,
    term:          TERM_NONE,
    at_line_start: 1'b1,
    kw_idx:        4'd0,
    kw_kind:       KW_NONE,
    length_found:  1'b0,
    val_phase:     VAL_IDLE
  };

  // One framed output transaction.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        msg_first;
    logic        in_body;
    logic        msg_last;
    logic [15:0] body_length;
    logic        dropped;
  } frame_res_t;

  // Lowercase of an ASCII letter; other bytes pass unchanged.
  function automatic logic [7:0] to_lower(input logic [7:0] b);
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
      return b + CASE_OFFSET;
    end
    return b;
  endfunction

  // Characters of the long header name, lowercase.
  function automatic logic [7:0] kw_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "c";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "t";
      4'd4:    ch = "e";
      4'd5:    ch = "n";
      4'd6:    ch = "t";
      4'd7:    ch = "-";
      4'd8:    ch = "l";
      4'd9:    ch = "e";
      4'd10:   ch = "n";
      4'd11:   ch = "g";
      4'd12:   ch = "t";
      4'd13:   ch = "h";
      4'd14:   ch = ":";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ rtl/sipf_if.sv @@
// Valid/ready stream interfaces for the input bytes and the framed output.
// Plain signal bundles; no package dependency.
interface sipf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface sipf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        msg_first;
  logic        in_body;
  logic        msg_last;
  logic [15:0] body_length;
  logic        dropped;

  modport source (
    output valid, output data_byte, output msg_first, output in_body,
    output msg_last, output body_length, output dropped, input ready
  );
  modport sink (
    input valid, input data_byte, input msg_first, input in_body,
    input msg_last, input body_length, input dropped, output ready
  );
endinterface

@@ rtl/sip_stream_message_framer.sv @@
// Top level of the SIP stream message framer: parser state, size limit register,
// output register and handshakes. Depends on sipf_pkg, sipf_if and sipf_step.
//
// Takes one byte of a SIP stream per transaction and returns one framed
// transaction per byte: the byte itself with first, body and last marks, the
// parsed Content-Length on the last byte of each message, and a dropped mark
// when a partial message exceeded max_msg_bytes and was discarded. The block
// accepts one byte every clock cycle while downstream ready holds; each result
// appears in the output register in the cycle after its byte is accepted, and
// a new byte is taken in the same cycle that the held result is taken, so
// throughput is set only by the downstream ready. The whole per-byte parse is
// a single pass of logic between the parser state registers and the output
// register. Write max_msg_bytes only while no transaction is in flight.
module sip_stream_message_framer #(
  parameter int COUNT_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_data,
  sipf_in_if.sink             in_ch,
  sipf_out_if.source          out_ch
);
  import sipf_pkg::*;

  hdr_state_t            st;
  hdr_state_t            st_next;
  logic [COUNT_BITS-1:0] acc;
  logic [COUNT_BITS-1:0] acc_next;
  logic [COUNT_BITS-1:0] rem;
  logic [COUNT_BITS-1:0] rem_next;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_next;
  logic [15:0]           max_msg_bytes;
  frame_res_t            res_next;
  frame_res_t            res;
  logic                  out_valid;
  logic                  accept;

  // A byte is taken whenever the output register is empty or being drained.
  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  sipf_step #(
    .COUNT_BITS(COUNT_BITS)
  ) u_step (
    .st           (st),
    .acc          (acc),
    .rem          (rem),
    .cnt          (cnt),
    .max_msg_bytes(max_msg_bytes),
    .stream_byte  (in_ch.stream_byte),
    .st_next      (st_next),
    .acc_next     (acc_next),
    .rem_next     (rem_next),
    .cnt_next     (cnt_next),
    .res          (res_next)
  );

  // Size limit register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_msg_bytes <= MAX_MSG_RESET;
    end else if (cfg_we) begin
      max_msg_bytes <= cfg_data;
    end
  end

  // Parser state advances on every accepted transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= HDR_CLEAR;
      acc <= '0;
      rem <= '0;
      cnt <= '0;
    end else if (accept) begin
      st  <= st_next;
      acc <= acc_next;
      rem <= rem_next;
      cnt <= cnt_next;
    end
  end

  // Output register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.data_byte   = res.data_byte;
  assign out_ch.msg_first   = res.msg_first;
  assign out_ch.in_body     = res.in_body;
  assign out_ch.msg_last    = res.msg_last;
  assign out_ch.body_length = res.body_length;
  assign out_ch.dropped     = res.dropped;

  // While in the body there is always at least one byte left to come.
  a_body_has_bytes : assert property (@(posedge clk) disable iff (rst)
    st.in_body_phase |-> rem != '0)
    else $error("body phase with no remaining bytes");

  // A value parse only runs after a length header name was found.
  a_value_needs_name : assert property (@(posedge clk) disable iff (rst)
    !st.length_found |-> st.val_phase == VAL_IDLE)
    else $error("value parse active without a length header");

  // A dropped message restarts, so the byte that reports it opens a message.
  a_drop_is_first : assert property (@(posedge clk) disable iff (rst)
    out_valid && res.dropped |-> res.msg_first)
    else $error("dropped mark without message start");

  // The length is only reported on the last byte of a message.
  a_len_on_last : assert property (@(posedge clk) disable iff (rst)
    out_valid && !res.msg_last |-> res.body_length == 16'd0)
    else $error("body length reported before message end");

  // An empty message counter means the parser is in its clean state.
  a_clean_start : assert property (@(posedge clk) disable iff (rst)
    cnt == '0 |-> st == HDR_CLEAR && acc == '0 && rem == '0)
    else $error("parser state left over at message start");

endmodule

@@ rtl/sipf_step.sv @@
// Per-byte next-state and result logic of the SIP message framer.
// Depends on sipf_pkg.
module sipf_step #(
  parameter int COUNT_BITS = 16
) (
  input  sipf_pkg::hdr_state_t    st,
  input  logic [COUNT_BITS-1:0]   acc,
  input  logic [COUNT_BITS-1:0]   rem,
  input  logic [COUNT_BITS-1:0]   cnt,
  input  logic [15:0]             max_msg_bytes,
  input  logic [7:0]              stream_byte,
  output sipf_pkg::hdr_state_t    st_next,
  output logic [COUNT_BITS-1:0]   acc_next,
  output logic [COUNT_BITS-1:0]   rem_next,
  output logic [COUNT_BITS-1:0]   cnt_next,
  output sipf_pkg::frame_res_t    res
);
  import sipf_pkg::*;

  localparam int LW = 33;
  localparam int PW = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  logic [LW-1:0]         lim;
  logic                  drop;
  logic                  first;
  logic                  body;
  logic                  last;
  logic                  hdr_end;
  logic                  is_digit;
  logic [7:0]            lb;
  logic [3:0]            dval;
  logic [PW-1:0]         prod;
  logic [COUNT_BITS-1:0] blen;
  logic [COUNT_BITS+15:0] blen_wide;
  hdr_state_t            s;
  logic [COUNT_BITS-1:0] a;
  logic [COUNT_BITS-1:0] r;
  logic [COUNT_BITS-1:0] c;

  // Effective size limit: zero acts as one, clipped to the counter maximum.
  always_comb begin
    lim = (max_msg_bytes == 16'd0) ? LW'(1) : LW'(max_msg_bytes);
    if (lim > LW'(CNT_MAX)) begin
      lim = LW'(CNT_MAX);
    end
  end

  // Byte classification and the decimal accumulate step.
  assign lb       = to_lower(stream_byte);
  assign is_digit = (stream_byte >= CHAR_ZERO) && (stream_byte <= CHAR_NINE);
  assign dval     = 4'(stream_byte - CHAR_ZERO);

  // Main parse for one byte.
  always_comb begin
    drop    = (LW'(cnt) >= lim);
    s       = drop ? HDR_CLEAR : st;
    a       = drop ? '0 : acc;
    r       = drop ? '0 : rem;
    c       = drop ? '0 : cnt;
    first   = (c == '0);
    body    = 1'b0;
    last    = 1'b0;
    blen    = '0;
    hdr_end = 1'b0;
    prod    = {1'b0, a, 3'b000} + {3'b000, a, 1'b0} + PW'(dval);
    c       = (c == CNT_MAX) ? c : c + 1'b1;

    if (s.in_body_phase) begin
      // Body byte: count down to the last one.
      body = 1'b1;
      if (r != '0) begin
        r = r - 1'b1;
      end
      if (r == '0) begin
        last = 1'b1;
        blen = a;
      end
    end else begin
      // Header byte: length value, keyword match, then terminator tracking.
      if (s.length_found) begin
        case (s.val_phase)
          VAL_BLANKS: begin
            if (stream_byte == CHAR_SPACE || stream_byte == CHAR_TAB) begin
              s.val_phase = VAL_BLANKS;
            end else if (is_digit) begin
              a           = COUNT_BITS'(dval);
              s.val_phase = VAL_DIGITS;
            end else begin
              s.val_phase = VAL_DONE;
            end
          end
          VAL_DIGITS: begin
            if (is_digit) begin
              a = (prod[PW-1:COUNT_BITS] != '0) ? CNT_MAX : prod[COUNT_BITS-1:0];
            end else begin
              s.val_phase = VAL_DONE;
            end
          end
          default: begin
            s.val_phase = s.val_phase;
          end
        endcase
      end else if (s.at_line_start) begin
        s.kw_idx  = 4'd0;
        s.kw_kind = KW_NONE;
        if (lb == CHAR_LOWER_C) begin
          s.kw_kind = KW_LONG;
          s.kw_idx  = 4'd1;
        end else if (lb == CHAR_LOWER_L) begin
          s.kw_kind = KW_COMPACT;
          s.kw_idx  = 4'd1;
        end
      end else if (s.kw_kind == KW_LONG) begin
        if (s.kw_idx < KW_LEN && lb == kw_char(s.kw_idx)) begin
          s.kw_idx = s.kw_idx + 1'b1;
          if (s.kw_idx == KW_LEN) begin
            s.length_found = 1'b1;
            s.val_phase    = VAL_BLANKS;
            a              = '0;
            s.kw_kind      = KW_NONE;
          end
        end else begin
          s.kw_kind = KW_NONE;
        end
      end else if (s.kw_kind == KW_COMPACT) begin
        if (stream_byte == CHAR_COLON) begin
          s.length_found = 1'b1;
          s.val_phase    = VAL_BLANKS;
          a              = '0;
        end
        s.kw_kind = KW_NONE;
      end
      s.at_line_start = (stream_byte == CHAR_LF);

      if (stream_byte == CHAR_CR) begin
        s.term = (s.term == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
      end else if (stream_byte == CHAR_LF) begin
        if (s.term == TERM_NONE) begin
          s.term = TERM_LF;
        end else if (s.term == TERM_CR) begin
          s.term = TERM_CRLF;
        end else begin
          hdr_end = 1'b1;
        end
      end else begin
        s.term = TERM_NONE;
      end

      // End of header: finish or enter the body.
      if (hdr_end) begin
        s.term = TERM_NONE;
        if (!s.length_found) begin
          a = '0;
        end
        if (a == '0) begin
          last = 1'b1;
        end else begin
          s.in_body_phase = 1'b1;
          r               = a;
        end
      end
    end

    // A finished message leaves a clean parser behind it.
    if (last) begin
      s = HDR_CLEAR;
      a = '0;
      r = '0;
      c = '0;
    end
  end

  assign st_next   = s;
  assign acc_next  = a;
  assign rem_next  = r;
  assign cnt_next  = c;
  assign blen_wide = {16'b0, blen};

  assign res = '{
    data_byte:   stream_byte,
    msg_first:   first,
    in_body:     body,
    msg_last:    last,
    body_length: blen_wide[15:0],
    dropped:     drop
  };

endmodule
